@@ rtl/core/snfcs_pkg.sv @@
// ----------------------------------------------------------------------------
// snfcs_pkg
// Shared types, codes and constants of the SPI NOR flash command sequencer.
// ----------------------------------------------------------------------------
package snfcs_pkg;

    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 24;
    localparam int LEN_W   = 20;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int TMO_W   = 10;
    localparam int ID_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int PAGE_BYTES_DEF   = 256;
    localparam int SECTOR_BYTES_DEF = 4096;

    // request and event codes
    localparam logic [CMD_W-1:0] CMD_IDENT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_HDATA = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RX    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd6;

    // result kinds
    localparam logic [KIND_W-1:0] K_SPI  = 3'd0;
    localparam logic [KIND_W-1:0] K_WANT = 3'd1;
    localparam logic [KIND_W-1:0] K_READ = 3'd2;
    localparam logic [KIND_W-1:0] K_OK   = 3'd3;
    localparam logic [KIND_W-1:0] K_ERR  = 3'd4;

    // flash opcodes
    localparam logic [BYTE_W-1:0] OP_WREN  = 8'h06;
    localparam logic [BYTE_W-1:0] OP_RDSR  = 8'h05;
    localparam logic [BYTE_W-1:0] OP_PP    = 8'h02;
    localparam logic [BYTE_W-1:0] OP_READ  = 8'h03;
    localparam logic [BYTE_W-1:0] OP_SE    = 8'h20;
    localparam logic [BYTE_W-1:0] OP_RDID  = 8'h9F;
    localparam logic [BYTE_W-1:0] OP_DUMMY = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROG_TMO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_TMO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_ID    = 2'd2;

    localparam logic [TMO_W-1:0] PROG_TMO_RST  = 10'd100;
    localparam logic [TMO_W-1:0] ERASE_TMO_RST = 10'd400;
    localparam logic [ID_W-1:0]  EXP_ID_RST    = 24'hEF4013;

    // sequencer phases
    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PH_W-1:0] PH_ID      = 4'd1;
    localparam logic [PH_W-1:0] PH_RD_HDR  = 4'd2;
    localparam logic [PH_W-1:0] PH_RD_DATA = 4'd3;
    localparam logic [PH_W-1:0] PH_ER_WREN = 4'd4;
    localparam logic [PH_W-1:0] PH_ER_HDR  = 4'd5;
    localparam logic [PH_W-1:0] PH_PE_CMD  = 4'd6;
    localparam logic [PH_W-1:0] PH_PE_STAT = 4'd7;
    localparam logic [PH_W-1:0] PH_PE_WAIT = 4'd8;
    localparam logic [PH_W-1:0] PH_WR_WREN = 4'd9;
    localparam logic [PH_W-1:0] PH_WR_HDR  = 4'd10;
    localparam logic [PH_W-1:0] PH_WR_WANT = 4'd11;
    localparam logic [PH_W-1:0] PH_WR_DATA = 4'd12;
    localparam logic [PH_W-1:0] PH_PW_CMD  = 4'd13;
    localparam logic [PH_W-1:0] PH_PW_STAT = 4'd14;
    localparam logic [PH_W-1:0] PH_PW_WAIT = 4'd15;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] spi_byte;
        logic              frame_end;
        logic [BYTE_W-1:0] read_byte;
        logic              last;
    } rsp_item_t;

    function automatic rsp_item_t make_item(
        input logic [KIND_W-1:0] kind,
        input logic [BYTE_W-1:0] sb,
        input logic              fe,
        input logic [BYTE_W-1:0] rb
    );
        rsp_item_t r;
        r.kind      = kind;
        r.spi_byte  = sb;
        r.frame_end = fe;
        r.read_byte = rb;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/core/snfcs_if.sv @@
// ----------------------------------------------------------------------------
// snfcs channel interfaces
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface snfcs_req_if;
    logic                          valid;
    logic                          ready;
    logic [snfcs_pkg::CMD_W-1:0]   cmd;
    logic [snfcs_pkg::ADDR_W-1:0]  addr;
    logic [snfcs_pkg::LEN_W-1:0]   length;
    logic [snfcs_pkg::BYTE_W-1:0]  data_byte;
    logic [snfcs_pkg::BYTE_W-1:0]  rx_byte;
    modport source (output valid, cmd, addr, length, data_byte, rx_byte, input ready);
    modport sink   (input valid, cmd, addr, length, data_byte, rx_byte, output ready);
endinterface

interface snfcs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [snfcs_pkg::KIND_W-1:0]  kind;
    logic [snfcs_pkg::BYTE_W-1:0]  spi_byte;
    logic                          frame_end;
    logic [snfcs_pkg::BYTE_W-1:0]  read_byte;
    logic                          last;
    modport source (output valid, kind, spi_byte, frame_end, read_byte, last, input ready);
    modport sink   (input valid, kind, spi_byte, frame_end, read_byte, last, output ready);
endinterface

interface snfcs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [snfcs_pkg::CFG_IDX_W-1:0]   index;
    logic [snfcs_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/spi_nor_flash_command_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_unit
// Turns host requests and flash byte events into SPI NOR byte streams.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  req     | in  | cmd, addr, length, data_byte, rx_byte
//  rsp     | out | kind, spi_byte, frame_end, read_byte, last
//  cfg     | in  | index, data (timeouts, expected id)
//
//  Each item is decoded in the cycle it is accepted; its up to two results go
//  into a four-entry queue; when it was empty, the first is offered the next cycle.
//  One item per cycle while the queue has room for two results; the result
//  side drains one per cycle, so items causing two results limit the rate.
//  A stalled rsp fills the queue and drops req.ready; cfg is taken every cycle.
//  Reset clears the state, the queue and loads the register defaults.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_unit #(
    parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = snfcs_pkg::SECTOR_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    snfcs_req_if.sink           req,
    snfcs_rsp_if.source         rsp,
    snfcs_cfg_if.sink           cfg
);

    localparam int CHUNK_W = $clog2(PAGE_BYTES + 1);
    localparam int QD      = 4;
    localparam int QP_W    = 2;
    localparam int QC_W    = 3;
    localparam logic [snfcs_pkg::LEN_W-1:0] LEN_ONE = 1;

    // configuration registers
    logic [snfcs_pkg::TMO_W-1:0] prog_tmo_reg;
    logic [snfcs_pkg::TMO_W-1:0] erase_tmo_reg;
    logic [snfcs_pkg::ID_W-1:0]  exp_id_reg;

    // sequencer state
    logic [snfcs_pkg::PH_W-1:0]   phase_reg,  phase_next;
    logic [snfcs_pkg::ADDR_W-1:0] addr_reg,   addr_next;
    logic [snfcs_pkg::LEN_W-1:0]  rem_reg,    rem_next;
    logic [CHUNK_W-1:0]           chunk_reg,  chunk_next;
    logic [2:0]                   fpos_reg,   fpos_next;
    logic [snfcs_pkg::TMO_W-1:0]  ticks_reg,  ticks_next;
    logic [snfcs_pkg::ID_W-1:0]   idsh_reg,   idsh_next;

    // results of the accepted item
    snfcs_pkg::rsp_item_t r0, r1;
    logic [1:0]           nres;

    // result queue
    snfcs_pkg::rsp_item_t q_mem [QD];
    logic [QP_W-1:0]      wp_reg, rp_reg;
    logic [QC_W-1:0]      cnt_reg;

    logic req_acc, rsp_acc;

    assign req.ready = (cnt_reg <= QC_W'(QD - 2));
    assign req_acc   = req.valid & req.ready;
    assign rsp.valid = (cnt_reg != '0);
    assign rsp_acc   = rsp.valid & rsp.ready;
    assign cfg.ready = 1'b1;

    assign rsp.kind      = q_mem[rp_reg].kind;
    assign rsp.spi_byte  = q_mem[rp_reg].spi_byte;
    assign rsp.frame_end = q_mem[rp_reg].frame_end;
    assign rsp.read_byte = q_mem[rp_reg].read_byte;
    assign rsp.last      = q_mem[rp_reg].last;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_tmo_reg  <= snfcs_pkg::PROG_TMO_RST;
            erase_tmo_reg <= snfcs_pkg::ERASE_TMO_RST;
            exp_id_reg    <= snfcs_pkg::EXP_ID_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                snfcs_pkg::REG_PROG_TMO:  prog_tmo_reg  <= cfg.data[snfcs_pkg::TMO_W-1:0];
                snfcs_pkg::REG_ERASE_TMO: erase_tmo_reg <= cfg.data[snfcs_pkg::TMO_W-1:0];
                snfcs_pkg::REG_EXP_ID:    exp_id_reg    <= cfg.data[snfcs_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    // address byte of the three-byte header
    function automatic logic [7:0] addr_byte(input logic [23:0] a, input logic [2:0] p);
        logic [7:0] b;
        case (p)
            3'd1:    b = a[23:16];
            3'd2:    b = a[15:8];
            3'd3:    b = a[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // item decode and next state
    always_comb
    begin
        logic [snfcs_pkg::ADDR_W-1:0] room;
        logic [snfcs_pkg::LEN_W-1:0]  rem_dec;
        logic [CHUNK_W-1:0]           chunk_dec;
        logic [snfcs_pkg::TMO_W-1:0]  tick_inc;
        logic [snfcs_pkg::TMO_W-1:0]  limit;
        logic                         wr;

        phase_next = phase_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        fpos_next  = fpos_reg;
        ticks_next = ticks_reg;
        idsh_next  = idsh_reg;
        r0   = snfcs_pkg::make_item(snfcs_pkg::K_SPI, 8'h00, 1'b0, 8'h00);
        r1   = r0;
        nres = 2'd0;
        rem_dec   = rem_reg - 1'b1;
        chunk_dec = chunk_reg - 1'b1;
        wr        = (phase_reg == snfcs_pkg::PH_PW_WAIT) || (phase_reg == snfcs_pkg::PH_PW_STAT);
        limit     = wr ? prog_tmo_reg : erase_tmo_reg;
        tick_inc  = (ticks_reg < 10'd1023) ? ticks_reg + 1'b1 : ticks_reg;
        room      = snfcs_pkg::ADDR_W'(PAGE_BYTES) -
                    (req.addr % snfcs_pkg::ADDR_W'(PAGE_BYTES));

        if (req.cmd <= snfcs_pkg::CMD_WRITE)
        begin
            if (phase_reg == snfcs_pkg::PH_IDLE)
            begin
                fpos_next = 3'd1;
                nres = 2'd1;
                case (req.cmd)
                    snfcs_pkg::CMD_IDENT:
                    begin
                        idsh_next  = '0;
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_RDID, 1'b0, 8'h00);
                        phase_next = snfcs_pkg::PH_ID;
                    end
                    snfcs_pkg::CMD_READ:
                    begin
                        if (req.length == '0)
                            r0 = snfcs_pkg::make_item(snfcs_pkg::K_OK, 8'h00, 1'b0, 8'h00);
                        else
                        begin
                            addr_next  = req.addr;
                            rem_next   = req.length;
                            r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_READ, 1'b0, 8'h00);
                            phase_next = snfcs_pkg::PH_RD_HDR;
                        end
                    end
                    snfcs_pkg::CMD_ERASE:
                    begin
                        addr_next  = req.addr - (req.addr % snfcs_pkg::ADDR_W'(SECTOR_BYTES));
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_WREN, 1'b1, 8'h00);
                        phase_next = snfcs_pkg::PH_ER_WREN;
                    end
                    default:
                    begin
                        if (req.length == '0)
                            r0 = snfcs_pkg::make_item(snfcs_pkg::K_OK, 8'h00, 1'b0, 8'h00);
                        else
                        begin
                            addr_next  = req.addr;
                            rem_next   = req.length;
                            chunk_next = (snfcs_pkg::ADDR_W'(req.length) < room) ?
                                         CHUNK_W'(req.length) : CHUNK_W'(room);
                            r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_WREN, 1'b1, 8'h00);
                            phase_next = snfcs_pkg::PH_WR_WREN;
                        end
                    end
                endcase
            end
        end
        else if (req.cmd == snfcs_pkg::CMD_HDATA)
        begin
            if (phase_reg == snfcs_pkg::PH_WR_WANT)
            begin
                nres = 2'd1;
                r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, req.data_byte,
                                          chunk_reg == CHUNK_W'(1), 8'h00);
                phase_next = snfcs_pkg::PH_WR_DATA;
            end
        end
        else if (req.cmd == snfcs_pkg::CMD_RX)
        begin
            case (phase_reg)
                snfcs_pkg::PH_ID:
                begin
                    nres = 2'd1;
                    if (fpos_reg >= 3'd2)
                        idsh_next = {idsh_reg[15:0], req.rx_byte};
                    if (fpos_reg < 3'd4)
                    begin
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_DUMMY,
                                                  fpos_reg == 3'd3, 8'h00);
                        fpos_next = fpos_reg + 1'b1;
                    end
                    else
                    begin
                        r0 = snfcs_pkg::make_item((idsh_next == exp_id_reg) ?
                                 snfcs_pkg::K_OK : snfcs_pkg::K_ERR, 8'h00, 1'b0, 8'h00);
                        phase_next = snfcs_pkg::PH_IDLE;
                    end
                end
                snfcs_pkg::PH_RD_HDR:
                begin
                    nres = 2'd1;
                    if (fpos_reg < 3'd4)
                    begin
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI,
                                 addr_byte(addr_reg, fpos_reg), 1'b0, 8'h00);
                        fpos_next = fpos_reg + 1'b1;
                    end
                    else
                    begin
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_DUMMY,
                                                  rem_reg == LEN_ONE, 8'h00);
                        phase_next = snfcs_pkg::PH_RD_DATA;
                    end
                end
                snfcs_pkg::PH_RD_DATA:
                begin
                    nres = 2'd2;
                    r0 = snfcs_pkg::make_item(snfcs_pkg::K_READ, 8'h00, 1'b0, req.rx_byte);
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        r1 = snfcs_pkg::make_item(snfcs_pkg::K_OK, 8'h00, 1'b0, 8'h00);
                        phase_next = snfcs_pkg::PH_IDLE;
                    end
                    else
                        r1 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_DUMMY,
                                                  rem_dec == LEN_ONE, 8'h00);
                end
                snfcs_pkg::PH_ER_WREN:
                begin
                    nres = 2'd1;
                    r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_SE, 1'b0, 8'h00);
                    fpos_next  = 3'd1;
                    phase_next = snfcs_pkg::PH_ER_HDR;
                end
                snfcs_pkg::PH_WR_WREN:
                begin
                    nres = 2'd1;
                    r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_PP, 1'b0, 8'h00);
                    fpos_next  = 3'd1;
                    phase_next = snfcs_pkg::PH_WR_HDR;
                end
                snfcs_pkg::PH_ER_HDR:
                begin
                    nres = 2'd1;
                    if (fpos_reg < 3'd4)
                    begin
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI,
                                 addr_byte(addr_reg, fpos_reg), fpos_reg == 3'd3, 8'h00);
                        fpos_next = fpos_reg + 1'b1;
                    end
                    else
                    begin
                        ticks_next = '0;
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_RDSR, 1'b0, 8'h00);
                        phase_next = snfcs_pkg::PH_PE_CMD;
                    end
                end
                snfcs_pkg::PH_WR_HDR:
                begin
                    nres = 2'd1;
                    if (fpos_reg < 3'd4)
                    begin
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI,
                                 addr_byte(addr_reg, fpos_reg), 1'b0, 8'h00);
                        fpos_next = fpos_reg + 1'b1;
                    end
                    else
                    begin
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_WANT, 8'h00, 1'b0, 8'h00);
                        phase_next = snfcs_pkg::PH_WR_WANT;
                    end
                end
                snfcs_pkg::PH_WR_DATA:
                begin
                    nres = 2'd1;
                    chunk_next = chunk_dec;
                    rem_next   = rem_dec;
                    addr_next  = addr_reg + 1'b1;
                    if (chunk_dec == '0)
                    begin
                        ticks_next = '0;
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_RDSR, 1'b0, 8'h00);
                        phase_next = snfcs_pkg::PH_PW_CMD;
                    end
                    else
                    begin
                        r0 = snfcs_pkg::make_item(snfcs_pkg::K_WANT, 8'h00, 1'b0, 8'h00);
                        phase_next = snfcs_pkg::PH_WR_WANT;
                    end
                end
                snfcs_pkg::PH_PE_CMD:
                begin
                    nres = 2'd1;
                    r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_DUMMY, 1'b1, 8'h00);
                    phase_next = snfcs_pkg::PH_PE_STAT;
                end
                snfcs_pkg::PH_PW_CMD:
                begin
                    nres = 2'd1;
                    r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_DUMMY, 1'b1, 8'h00);
                    phase_next = snfcs_pkg::PH_PW_STAT;
                end
                snfcs_pkg::PH_PE_STAT, snfcs_pkg::PH_PW_STAT:
                begin
                    if (!req.rx_byte[0])
                    begin
                        nres = 2'd1;
                        if (wr && rem_reg != '0)
                        begin
                            room = snfcs_pkg::ADDR_W'(PAGE_BYTES) -
                                   (addr_reg % snfcs_pkg::ADDR_W'(PAGE_BYTES));
                            chunk_next = (snfcs_pkg::ADDR_W'(rem_reg) < room) ?
                                         CHUNK_W'(rem_reg) : CHUNK_W'(room);
                            r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_WREN,
                                                      1'b1, 8'h00);
                            phase_next = snfcs_pkg::PH_WR_WREN;
                        end
                        else
                        begin
                            r0 = snfcs_pkg::make_item(snfcs_pkg::K_OK, 8'h00, 1'b0, 8'h00);
                            phase_next = snfcs_pkg::PH_IDLE;
                        end
                    end
                    else
                        phase_next = wr ? snfcs_pkg::PH_PW_WAIT : snfcs_pkg::PH_PE_WAIT;
                end
                default: ;
            endcase
        end
        else if (req.cmd == snfcs_pkg::CMD_TICK)
        begin
            if (phase_reg == snfcs_pkg::PH_PE_WAIT || phase_reg == snfcs_pkg::PH_PW_WAIT)
            begin
                nres = 2'd1;
                ticks_next = tick_inc;
                if (tick_inc >= limit)
                begin
                    r0 = snfcs_pkg::make_item(snfcs_pkg::K_ERR, 8'h00, 1'b0, 8'h00);
                    phase_next = snfcs_pkg::PH_IDLE;
                end
                else
                begin
                    r0 = snfcs_pkg::make_item(snfcs_pkg::K_SPI, snfcs_pkg::OP_RDSR, 1'b0, 8'h00);
                    phase_next = wr ? snfcs_pkg::PH_PW_CMD : snfcs_pkg::PH_PE_CMD;
                end
            end
        end

        // mark the final result of the item
        if (nres == 2'd1)
            r0.last = 1'b1;
        if (nres == 2'd2)
            r1.last = 1'b1;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= snfcs_pkg::PH_IDLE;
            addr_reg  <= '0;
            rem_reg   <= '0;
            chunk_reg <= '0;
            fpos_reg  <= '0;
            ticks_reg <= '0;
            idsh_reg  <= '0;
        end
        else if (req_acc)
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            chunk_reg <= chunk_next;
            fpos_reg  <= fpos_next;
            ticks_reg <= ticks_next;
            idsh_reg  <= idsh_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (req_acc && nres != 2'd0)
            q_mem[wp_reg] <= r0;
        if (req_acc && nres == 2'd2)
            q_mem[wp_reg + 1'b1] <= r1;
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (req_acc)
                wp_reg <= wp_reg + QP_W'(nres);
            if (rsp_acc)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + QC_W'(req_acc ? nres : 2'd0) - QC_W'(rsp_acc);
        end
    end

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QC_W'(QD))
        else $error("result queue overflow");

    a_frame_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != snfcs_pkg::PH_IDLE |-> fpos_reg != 3'd0)
        else $error("busy phase with no frame position");

    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_reg <= CHUNK_W'(PAGE_BYTES))
        else $error("chunk larger than a page");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Regression bench for the SPI NOR flash command sequencer. A behavioral
// flash model answers every emitted byte; a predictor tracks the sequencer
// state and checks each result item in order against its expectation.
// ----------------------------------------------------------------------------
module tb;
    import snfcs_pkg::*;

    logic clk;
    logic rst_n;

    snfcs_req_if req ();
    snfcs_rsp_if rsp ();
    snfcs_cfg_if cfg ();

    spi_nor_flash_command_sequencer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    localparam int CYCLE_LIMIT = 2000000;

    // predictor copy of registers and state
    logic [TMO_W-1:0]  prog_tmo;
    logic [TMO_W-1:0]  erase_tmo;
    logic [ID_W-1:0]   exp_id;
    logic [PH_W-1:0]   ph;
    logic [23:0]       addr_cnt;
    logic [19:0]       bytes_left;
    logic [12:0]       chunk_left;
    logic [2:0]        frame_pos;
    logic [9:0]        ticks;
    logic [23:0]       id_acc;

    rsp_item_t expected_rsp[$];
    rsp_item_t step_out[$];

    int errors;
    int cycles;
    int items_sent;
    int rsp_seen;
    int hold_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // long receiver hold, counted down here
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
        end
    end

    task automatic report(input string what);
        errors++;
        if (errors < 40)
            $display("mismatch @%0d: %s", cycles, what);
    endtask

    // predictor helpers
    function automatic void put(input logic [2:0] k, input logic [7:0] sb,
                                input logic fe, input logic [7:0] rb);
        rsp_item_t r;
        r.kind = k; r.spi_byte = sb; r.frame_end = fe; r.read_byte = rb; r.last = 1'b0;
        if (step_out.size() < 2) step_out.push_back(r);
    endfunction

    function automatic logic [7:0] addr_sel(input logic [23:0] a, input logic [2:0] p);
        case (p)
            3'd1: return a[23:16];
            3'd2: return a[15:8];
            3'd3: return a[7:0];
            default: return 8'h00;
        endcase
    endfunction

    function automatic void done(input logic [2:0] k);
        put(k, 8'h00, 1'b0, 8'h00);
        ph = PH_IDLE;
    endfunction

    function automatic void open_poll(input bit wr);
        ticks = '0;
        put(K_SPI, OP_RDSR, 1'b0, 8'h00);
        ph = wr ? PH_PW_CMD : PH_PE_CMD;
    endfunction

    function automatic void open_chunk();
        int room;
        room = PAGE_BYTES_DEF - int'(addr_cnt % PAGE_BYTES_DEF);
        chunk_left = 13'((int'(bytes_left) < room) ? int'(bytes_left) : room);
        put(K_SPI, OP_WREN, 1'b1, 8'h00);
        ph = PH_WR_WREN;
    endfunction

    function automatic void status_seen(input logic [7:0] st, input bit wr);
        if (!st[0])
        begin
            if (wr && bytes_left != 0) open_chunk();
            else done(K_OK);
        end
        else
            ph = wr ? PH_PW_WAIT : PH_PE_WAIT;
    endfunction

    // one input item through the sequencer
    function automatic void sequencer_step(input logic [2:0] c, input logic [23:0] a,
                                           input logic [19:0] len, input logic [7:0] db,
                                           input logic [7:0] rx);
        logic [2:0] fp;
        bit wr;
        rsp_item_t r;
        step_out.delete();
        fp = frame_pos;
        if (c <= CMD_WRITE)
        begin
            if (ph == PH_IDLE)
            begin
                frame_pos = 3'd1;
                case (c)
                    CMD_IDENT:
                    begin
                        id_acc = '0; put(K_SPI, OP_RDID, 1'b0, 8'h00); ph = PH_ID;
                    end
                    CMD_READ:
                        if (len == 0) done(K_OK);
                        else
                        begin
                            addr_cnt = a; bytes_left = len;
                            put(K_SPI, OP_READ, 1'b0, 8'h00); ph = PH_RD_HDR;
                        end
                    CMD_ERASE:
                    begin
                        addr_cnt = 24'(a - (a % SECTOR_BYTES_DEF));
                        put(K_SPI, OP_WREN, 1'b1, 8'h00); ph = PH_ER_WREN;
                    end
                    default:
                        if (len == 0) done(K_OK);
                        else
                        begin
                            addr_cnt = a; bytes_left = len; open_chunk();
                        end
                endcase
            end
        end
        else if (c == CMD_HDATA)
        begin
            if (ph == PH_WR_WANT)
            begin
                put(K_SPI, db, chunk_left == 13'd1, 8'h00); ph = PH_WR_DATA;
            end
        end
        else if (c == CMD_RX)
        begin
            case (ph)
                PH_ID:
                begin
                    if (fp >= 3'd2) id_acc = {id_acc[15:0], rx};
                    if (fp < 3'd4)
                    begin
                        put(K_SPI, OP_DUMMY, fp == 3'd3, 8'h00); frame_pos = fp + 1'b1;
                    end
                    else done(id_acc == exp_id ? K_OK : K_ERR);
                end
                PH_RD_HDR:
                    if (fp < 3'd4)
                    begin
                        put(K_SPI, addr_sel(addr_cnt, fp), 1'b0, 8'h00); frame_pos = fp + 1'b1;
                    end
                    else
                    begin
                        put(K_SPI, OP_DUMMY, bytes_left == 20'd1, 8'h00); ph = PH_RD_DATA;
                    end
                PH_RD_DATA:
                begin
                    put(K_READ, 8'h00, 1'b0, rx);
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == 0) done(K_OK);
                    else put(K_SPI, OP_DUMMY, bytes_left == 20'd1, 8'h00);
                end
                PH_ER_WREN, PH_WR_WREN:
                begin
                    put(K_SPI, ph == PH_ER_WREN ? OP_SE : OP_PP, 1'b0, 8'h00);
                    frame_pos = 3'd1;
                    ph = (ph == PH_ER_WREN) ? PH_ER_HDR : PH_WR_HDR;
                end
                PH_ER_HDR:
                    if (fp < 3'd4)
                    begin
                        put(K_SPI, addr_sel(addr_cnt, fp), fp == 3'd3, 8'h00);
                        frame_pos = fp + 1'b1;
                    end
                    else open_poll(1'b0);
                PH_WR_HDR:
                    if (fp < 3'd4)
                    begin
                        put(K_SPI, addr_sel(addr_cnt, fp), 1'b0, 8'h00); frame_pos = fp + 1'b1;
                    end
                    else
                    begin
                        put(K_WANT, 8'h00, 1'b0, 8'h00); ph = PH_WR_WANT;
                    end
                PH_WR_DATA:
                begin
                    chunk_left = chunk_left - 1'b1;
                    bytes_left = bytes_left - 1'b1;
                    addr_cnt = addr_cnt + 1'b1;
                    if (chunk_left == 0) open_poll(1'b1);
                    else
                    begin
                        put(K_WANT, 8'h00, 1'b0, 8'h00); ph = PH_WR_WANT;
                    end
                end
                PH_PE_CMD:
                begin
                    put(K_SPI, OP_DUMMY, 1'b1, 8'h00); ph = PH_PE_STAT;
                end
                PH_PW_CMD:
                begin
                    put(K_SPI, OP_DUMMY, 1'b1, 8'h00); ph = PH_PW_STAT;
                end
                PH_PE_STAT: status_seen(rx, 1'b0);
                PH_PW_STAT: status_seen(rx, 1'b1);
                default: ;
            endcase
        end
        else if (c == CMD_TICK)
        begin
            if (ph == PH_PE_WAIT || ph == PH_PW_WAIT)
            begin
                wr = (ph == PH_PW_WAIT);
                if (ticks < 10'd1023) ticks = ticks + 1'b1;
                if (ticks >= (wr ? prog_tmo : erase_tmo)) done(K_ERR);
                else
                begin
                    put(K_SPI, OP_RDSR, 1'b0, 8'h00);
                    ph = wr ? PH_PW_CMD : PH_PE_CMD;
                end
            end
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i])
        begin
            r = step_out[i];
            expected_rsp.push_back(r);
        end
    endfunction

    // send one item, predict at the accepting edge; valid stays up for the next one
    task automatic send_item(input logic [2:0] c, input logic [23:0] a,
                             input logic [19:0] len, input logic [7:0] db,
                             input logic [7:0] rx, input int gap);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= c; req.addr <= a; req.length <= len;
        req.data_byte <= db; req.rx_byte <= rx;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sequencer_step(c, a, len, db, rx);
        items_sent++;
    endtask

    task automatic send_gap(input logic [2:0] c, input logic [23:0] a,
                            input logic [19:0] len, input logic [7:0] db,
                            input logic [7:0] rx);
        send_item(c, a, len, db, rx, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0);
    endtask

    task automatic send_stray();
        send_gap(3'($urandom_range(0, 7)), 24'($urandom), 20'($urandom),
                 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            REG_PROG_TMO:  prog_tmo = val[9:0];
            REG_ERASE_TMO: erase_tmo = val[9:0];
            REG_EXP_ID:    exp_id = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // answer the flash side: random rx, with busy status sometimes
    function automatic logic [7:0] flash_reply(input int busy_pct);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (ph == PH_PE_STAT || ph == PH_PW_STAT)
            v[0] = ($urandom_range(0, 99) < busy_pct);
        return v;
    endfunction

    // drive a whole request to completion with random content
    task automatic run_request(input logic [2:0] c, input logic [23:0] a,
                               input logic [19:0] len, input int busy_pct);
        int guard;
        send_gap(c, a, len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        guard = 0;
        while (ph != PH_IDLE && guard < 4000)
        begin
            guard++;
            if ($urandom_range(0, 40) == 0)
                send_stray();
            else if (ph == PH_WR_WANT)
                send_gap(CMD_HDATA, 0, 0, 8'($urandom_range(0, 255)), 0);
            else if (ph == PH_PE_WAIT || ph == PH_PW_WAIT)
                send_gap(CMD_TICK, 0, 0, 0, 0);
            else
                send_gap(CMD_RX, 0, 0, 0, flash_reply(busy_pct));
        end
    endtask

    // result checker with random receiver stalls
    initial
    begin
        int wait_left;
        rsp.ready = 1'b0;
        wait_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                rsp_item_t e;
                rsp_seen++;
                if (expected_rsp.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    e = expected_rsp.pop_front();
                    if (rsp.kind !== e.kind)
                        report($sformatf("kind %0d exp %0d", rsp.kind, e.kind));
                    if (rsp.spi_byte !== e.spi_byte)
                        report($sformatf("spi_byte %h exp %h", rsp.spi_byte, e.spi_byte));
                    if (rsp.frame_end !== e.frame_end)
                        report($sformatf("frame_end %b exp %b", rsp.frame_end, e.frame_end));
                    if (rsp.read_byte !== e.read_byte)
                        report($sformatf("read_byte %h exp %h", rsp.read_byte, e.read_byte));
                    if (rsp.last !== e.last)
                        report($sformatf("last %b exp %b", rsp.last, e.last));
                end
            end
            if (hold_cycles > 0)
                rsp.ready <= 1'b0;
            else if (wait_left > 0)
            begin
                wait_left--;
                rsp.ready <= 1'b0;
            end
            else if (rsp.valid && rsp.ready || !rsp.ready)
            begin
                wait_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
                rsp.ready <= (wait_left == 0);
            end
        end
    end

    task automatic test_directed();
        write_reg(REG_PROG_TMO, 24'd1);
        write_reg(REG_ERASE_TMO, 24'd3);
        write_reg(REG_EXP_ID, 24'hEF4013);
        send_item(CMD_READ, 24'hFFFFFF, 20'd0, 8'h00, 8'h00, 0);
        send_item(CMD_WRITE, 24'h000000, 20'd0, 8'hFF, 8'hFF, 0);
        send_item(CMD_HDATA, 0, 0, 8'hFF, 0, 0);
        send_item(CMD_RX, 0, 0, 0, 8'hFF, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0);
        send_item(3'd7, 24'hFFFFFF, 20'hFFFFF, 8'hFF, 8'hFF, 0);
        run_request(CMD_IDENT, 0, 0, 0);
        run_request(CMD_READ, 24'hFFFFFE, 20'd3, 0);
        run_request(CMD_ERASE, 24'hFFFFFF, 0, 100);
        run_request(CMD_WRITE, 24'hFFFFFD, 20'd5, 100);
        wait_drained();
    endtask

    task automatic test_identify();
        logic [23:0] id;
        id = 24'($urandom);
        write_reg(REG_EXP_ID, id);
        send_gap(CMD_IDENT, 0, 0, 0, 0);
        send_gap(CMD_RX, 0, 0, 0, 0);
        send_gap(CMD_RX, 0, 0, 0, id[23:16]);
        send_gap(CMD_RX, 0, 0, 0, id[15:8]);
        send_gap(CMD_RX, 0, 0, 0, id[7:0]);
        run_request(CMD_IDENT, 0, 0, 0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        run_request(CMD_READ, 24'($urandom), 20'd40, 0);
        wait_drained();
    endtask

    task automatic test_random(input int n_items);
        int kind_sel;
        logic [23:0] wa;
        logic [19:0] wl;
        while (items_sent < n_items)
        begin
            kind_sel = $urandom_range(0, 9);
            if (kind_sel < 2) run_request(CMD_IDENT, 0, 0, 0);
            else if (kind_sel < 4)
                run_request(CMD_READ, 24'($urandom), 20'($urandom_range(0, 12)), 0);
            else if (kind_sel < 6)
                run_request(CMD_ERASE, 24'($urandom), 0, $urandom_range(0, 90));
            else if (kind_sel < 9)
            begin
                wa = ($urandom_range(0, 1) != 0) ? 24'hFFFFF0 : 24'h0;
                wa = wa | 24'($urandom_range(0, 255)) | 24'($urandom << 8);
                wl = ($urandom_range(0, 30) == 0) ? 20'($urandom_range(200, 600))
                                                  : 20'($urandom_range(0, 20));
                run_request(CMD_WRITE, wa, wl, $urandom_range(0, 90));
            end
            else
                send_stray();
        end
        wait_drained();
    endtask

    initial
    begin
        errors = 0; items_sent = 0; rsp_seen = 0; hold_cycles = 0;
        prog_tmo = PROG_TMO_RST; erase_tmo = ERASE_TMO_RST; exp_id = EXP_ID_RST;
        ph = PH_IDLE; addr_cnt = '0; bytes_left = '0; chunk_left = '0;
        frame_pos = '0; ticks = '0; id_acc = '0;
        req.valid = 1'b0; req.cmd = '0; req.addr = '0; req.length = '0;
        req.data_byte = '0; req.rx_byte = '0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        @(posedge rst_n);
        @(posedge clk);
        run_request(CMD_ERASE, 24'h001234, 0, 0);
        wait_drained();
        test_directed();
        test_identify();
        test_backpressure();
        write_reg(REG_PROG_TMO, 24'd1023);
        write_reg(REG_ERASE_TMO, 24'd0);
        test_random(700);
        write_reg(REG_PROG_TMO, 24'd0);
        write_reg(REG_ERASE_TMO, 24'd1023);
        write_reg(REG_EXP_ID, 24'hFFFFFF);
        test_identify();
        test_random(1400);
        write_reg(REG_PROG_TMO, 24'd5);
        write_reg(REG_ERASE_TMO, 24'd7);
        write_reg(REG_EXP_ID, 24'h000000);
        test_random(2100);
        wait_drained();
        $display("covered %0d items and %0d results over identify, read, erase, write",
                 items_sent, rsp_seen);
        $display("with busy polls, timeouts, stray events and output stalls");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
